/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the message ring RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define VLMR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define VLMR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/vlmr_pkg.sv */
// ----------------------------------------------------------------------------
// vlmr_pkg
// Sizes, codes and state encoding for the variable-length message ring.
// ----------------------------------------------------------------------------
package vlmr_pkg;

	// Ring geometry
	localparam int BUF_BYTES = 4096;
	localparam int HDR_BYTES = 8;
	localparam int MAX_MSG   = 64;

	// Derived widths
	localparam int AW = $clog2(BUF_BYTES);      // ring address
	localparam int FW = AW + 1;                 // free count, holds BUF_BYTES
	localparam int LW = 7;                      // msg_len field
	localparam int BW = 8;                      // one ring word
	localparam int HW = $clog2(HDR_BYTES);      // header byte index
	localparam int CW = $clog2(MAX_MSG + 1);    // receive byte count

	// Receive gives up after this many wrap-marker skips
	localparam int SKIP_LIMIT = 3;
	localparam int PW = $clog2(SKIP_LIMIT + 1);

	typedef logic [AW-1:0] addr_t;
	typedef logic [FW-1:0] free_t;

	// Header kind byte
	localparam logic [BW-1:0] KIND_MARK = 8'd0;
	localparam logic [BW-1:0] KIND_MSG  = 8'd1;

	typedef enum logic [1:0] {
		CMD_BEGIN = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_RECV  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_NO_ROOM = 3'd1,
		STAT_WRAP    = 3'd2,
		STAT_EMPTY   = 3'd3,
		STAT_DATA    = 3'd4,
		STAT_NO_SEND = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HDR,
		S_RX_CHECK,
		S_RX_KIND,
		S_RX_LEN,
		S_RX_DATA
	} state_t;

endpackage

/* src/variable_length_message_ring_top.sv */
// Begin, data and undefined commands: registered result in the cycle after accept; a
// begin that fits then stays busy in S_HDR writing the header, one word a cycle.
// Receive: walks S_RX_CHECK and S_RX_KIND, once more per wrap-marker skip, giving empty
// from S_RX_CHECK; else S_RX_LEN, then one byte per cycle, paced by the ring read port.
// Reset clears pointers, open-send count and sets free to the buffer size; the ring
// RAM itself is not cleared. Results cannot be stalled by the receiver.
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// variable_length_message_ring_top
// Byte ring of framed messages with send, data and receive commands.
// ----------------------------------------------------------------------------
module variable_length_message_ring_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           cmd,
	input  logic [vlmr_pkg::LW-1:0] msg_len,
	input  logic [7:0]           data_byte,
	output logic                 res_valid,
	output logic [2:0]           status,
	output logic [7:0]           out_byte,
	output logic                 last
);

	import vlmr_pkg::*;

	state_t state_q, state_nxt;

	// Ring state
	addr_t         wp_q, rp_q;
	free_t         free_q;
	logic [LW-1:0] btw_q;
	logic [PW-1:0] pass_q;

	// Header write and receive working registers
	addr_t         hdr_base_q;
	logic [LW-1:0] hdr_len_q;
	logic [HW-1:0] hdr_idx_q;
	logic [BW-1:0] len_q;
	logic [CW-1:0] n_q, idx_q;

	// Result registers
	logic          res_valid_q;
	status_t       status_q;
	logic [BW-1:0] out_byte_q;
	logic          last_q;

	// Ring RAM port
	logic          mem_we;
	addr_t         mem_waddr, mem_raddr;
	logic [BW-1:0] mem_wdata, mem_rdata;

	// Combinational results
	logic          res_v_nxt, res_l_nxt;
	status_t       res_st_nxt;
	logic [BW-1:0] res_b_nxt;

	logic          accept;
	free_t         left, need, skip_free, free_rel;
	logic [FW:0]   rel_sum;
	logic          too_long, wrap_case, mark_ok, fit_ok, rx_empty, rx_quit;
	addr_t         data_addr, rp_adv;
	logic [CW-1:0] n_calc;
	logic [BW-1:0] len_cur;
	logic          is_last;
	logic          in_rx;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign in_rx  = state_q inside {S_RX_CHECK, S_RX_KIND, S_RX_LEN, S_RX_DATA};

	// Begin-send checks
	assign left      = free_t'(BUF_BYTES) - {1'b0, wp_q};
	assign need      = free_t'(msg_len) + free_t'(HDR_BYTES);
	assign too_long  = msg_len > LW'(MAX_MSG);
	assign wrap_case = need >= left;
	assign mark_ok   = (rp_q != '0) && (left < free_q);
	assign fit_ok    = (need + free_t'(1)) < free_q;
	assign data_addr = wp_q - addr_t'(btw_q);

	// Receive checks and pointer release
	assign rx_empty  = (free_q >= free_t'(BUF_BYTES)) || (wp_q == rp_q);
	assign rx_quit   = (pass_q == PW'(SKIP_LIMIT)) || rx_empty;
	assign skip_free = free_q + (free_t'(BUF_BYTES) - {1'b0, rp_q});
	assign n_calc    = (mem_rdata > BW'(MAX_MSG)) ? CW'(MAX_MSG) : CW'(mem_rdata);
	assign len_cur   = (state_q == S_RX_LEN) ? mem_rdata : len_q;
	assign rp_adv    = rp_q + addr_t'(len_cur) + addr_t'(HDR_BYTES);
	assign rel_sum   = (FW+1)'(free_q) + (FW+1)'(len_cur) + (FW+1)'(HDR_BYTES);
	assign free_rel  = (rel_sum > (FW+1)'(BUF_BYTES)) ? free_t'(BUF_BYTES)
		: rel_sum[FW-1:0];
	assign is_last   = (idx_q == n_q - CW'(1));

	vlmr_ram #(
		.DEPTH (BUF_BYTES),
		.WIDTH (BW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_BEGIN: begin
							if (!too_long && !wrap_case && fit_ok) begin
								state_nxt = S_HDR;
							end
						end
						CMD_RECV: state_nxt = S_RX_CHECK;
						default:  state_nxt = S_IDLE;
					endcase
				end
			end
			S_HDR: begin
				if (hdr_idx_q == HW'(HDR_BYTES - 1)) begin
					state_nxt = S_IDLE;
				end
			end
			S_RX_CHECK: state_nxt = rx_quit ? S_IDLE : S_RX_KIND;
			S_RX_KIND:  state_nxt = (mem_rdata != KIND_MSG) ? S_RX_CHECK : S_RX_LEN;
			S_RX_LEN:   state_nxt = (n_calc == '0) ? S_IDLE : S_RX_DATA;
			S_RX_DATA: begin
				if (is_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// RAM control and result words
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = wp_q;
		mem_wdata  = KIND_MSG;
		mem_raddr  = rp_q;
		res_v_nxt  = 1'b0;
		res_st_nxt = STAT_OK;
		res_b_nxt  = '0;
		res_l_nxt  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_BEGIN: begin
							res_v_nxt = 1'b1;
							res_l_nxt = 1'b1;
							if (too_long) begin
								res_st_nxt = STAT_NO_ROOM;
							end else if (wrap_case) begin
								if (mark_ok) begin
									mem_we     = 1'b1;
									mem_wdata  = KIND_MARK;
									res_st_nxt = STAT_WRAP;
								end else begin
									res_st_nxt = STAT_NO_ROOM;
								end
							end else if (fit_ok) begin
								mem_we = 1'b1;
							end else begin
								res_st_nxt = STAT_NO_ROOM;
							end
						end
						CMD_DATA: begin
							res_v_nxt = 1'b1;
							res_l_nxt = 1'b1;
							if (btw_q == '0) begin
								res_st_nxt = STAT_NO_SEND;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = data_addr;
								mem_wdata = data_byte;
							end
						end
						CMD_RECV: res_v_nxt = 1'b0;
						default: begin
							res_v_nxt  = 1'b1;
							res_l_nxt  = 1'b1;
							res_st_nxt = STAT_NO_SEND;
						end
					endcase
				end
			end
			// Header bytes after the kind byte: length, then zero fill
			S_HDR: begin
				mem_we    = 1'b1;
				mem_waddr = hdr_base_q + addr_t'(hdr_idx_q);
				mem_wdata = (hdr_idx_q == HW'(1)) ? BW'(hdr_len_q) : '0;
			end
			S_RX_CHECK: begin
				mem_raddr = rp_q;
				if (rx_quit) begin
					res_v_nxt  = 1'b1;
					res_l_nxt  = 1'b1;
					res_st_nxt = STAT_EMPTY;
				end
			end
			S_RX_KIND: mem_raddr = rp_q + addr_t'(1);
			S_RX_LEN: begin
				mem_raddr = rp_q + addr_t'(HDR_BYTES);
				if (n_calc == '0) begin
					res_v_nxt = 1'b1;
					res_l_nxt = 1'b1;
				end
			end
			S_RX_DATA: begin
				mem_raddr  = rp_q + addr_t'(HDR_BYTES) + addr_t'(idx_q) + addr_t'(1);
				res_v_nxt  = 1'b1;
				res_st_nxt = STAT_DATA;
				res_b_nxt  = mem_rdata;
				res_l_nxt  = is_last;
			end
			default: res_v_nxt = 1'b0;
		endcase
	end

	// Control state and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			free_q      <= free_t'(BUF_BYTES);
			btw_q       <= '0;
			pass_q      <= '0;
			hdr_idx_q   <= '0;
			idx_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			res_valid_q <= res_v_nxt;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_BEGIN: begin
								// any begin within the length limit closes the open send
								if (!too_long) begin
									if (wrap_case) begin
										btw_q <= '0;
										if (mark_ok) begin
											free_q <= free_q - left;
											wp_q   <= '0;
										end
									end else if (fit_ok) begin
										free_q    <= free_q - need;
										wp_q      <= wp_q + need[AW-1:0];
										btw_q     <= msg_len;
										hdr_idx_q <= HW'(1);
									end else begin
										btw_q <= '0;
									end
								end
							end
							CMD_DATA: begin
								if (btw_q != '0) begin
									btw_q <= btw_q - LW'(1);
								end
							end
							CMD_RECV: pass_q <= '0;
							default:  pass_q <= pass_q;
						endcase
					end
				end
				S_HDR: hdr_idx_q <= hdr_idx_q + HW'(1);
				// Wrap marker: release the tail and restart at zero
				S_RX_KIND: begin
					if (mem_rdata != KIND_MSG) begin
						free_q <= skip_free;
						rp_q   <= '0;
						pass_q <= pass_q + PW'(1);
					end
				end
				S_RX_LEN: begin
					idx_q <= '0;
					if (n_calc == '0) begin
						rp_q   <= rp_adv;
						free_q <= free_rel;
					end
				end
				S_RX_DATA: begin
					idx_q <= idx_q + CW'(1);
					if (is_last) begin
						rp_q   <= rp_adv;
						free_q <= free_rel;
					end
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		status_q   <= res_st_nxt;
		out_byte_q <= res_b_nxt;
		last_q     <= res_l_nxt;
		if (state_q == S_IDLE) begin
			hdr_base_q <= wp_q;
			hdr_len_q  <= msg_len;
		end
		if (state_q == S_RX_LEN) begin
			len_q <= mem_rdata;
			n_q   <= n_calc;
		end
	end

	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// A result only follows an accepted command or ongoing work
	`VLMR_ASSERT_IMPL(a_res_cause, clk, arst_n, res_valid,
		$past(start || busy), "result without a command")
	// Byte streaming stays within the clamped length
	`VLMR_ASSERT_IMPL(a_rx_count, clk, arst_n, state_q == S_RX_DATA,
		(n_q != '0) && (idx_q < n_q), "receive index out of range")
	// Receive states never write the ring
	`VLMR_ASSERT_IMPL(a_rx_no_write, clk, arst_n, in_rx,
		!mem_we, "ring write during receive")
	// A wrap retry leaves the write pointer at zero
	`VLMR_ASSERT_IMPL(a_wrap_wp, clk, arst_n, res_valid && (status_q == STAT_WRAP),
		wp_q == '0, "write pointer not reset on wrap")

endmodule

/* src/vlmr_ram.sv */
// ----------------------------------------------------------------------------
// vlmr_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vlmr_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the variable-length message ring. A short scripted
// run covers the edge cases, then random send, data and receive words run
// through three idle phases. Every result is checked against a cycle-free
// model of the ring held in the bench.
// ----------------------------------------------------------------------------
module tb;
	import vlmr_pkg::*;

	localparam logic [1:0] CMD_UNDEF   = 2'd3;
	localparam int         CYCLE_LIMIT = 100_000;
	localparam int         PHASE_WORDS = 45;
	localparam int         DRAIN_WAIT  = 80;

	typedef struct packed {
		status_t     st;
		logic [7:0]  ob;
		logic        lst;
	} ring_answer_t;

	typedef struct {
		logic [1:0]     c;
		logic [LW-1:0]  len;
		logic [7:0]     b;
		bit             known;
		status_t        st;
	} script_row_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	logic [1:0]     cmd;
	logic [LW-1:0]  msg_len;
	logic [7:0]     data_byte;
	logic           res_valid;
	logic [2:0]     status;
	logic [7:0]     out_byte;
	logic           last;

	// Ring model state
	logic [7:0]     ring_mem [BUF_BYTES];
	bit             ring_written [BUF_BYTES];
	int             wr_ptr;
	int             rd_ptr;
	int             free_cnt;
	int             owed;

	ring_answer_t   step_answers [$];
	ring_answer_t   answers_due [$];

	int             errors;
	int             cycle_count;
	int             idle_pct;
	int             recv_pct;
	script_row_t    script [23];

	variable_length_message_ring_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.msg_len   (msg_len),
		.data_byte (data_byte),
		.res_valid (res_valid),
		.status    (status),
		.out_byte  (out_byte),
		.last      (last)
	);

	always #4 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic void ring_put(int a, logic [7:0] v);
		ring_mem[a % BUF_BYTES] = v;
		ring_written[a % BUF_BYTES] = 1'b1;
	endfunction

	function automatic void note(status_t s, logic [7:0] v, logic l);
		step_answers.push_back('{s, v, l});
	endfunction

	// Answers of the ring to one word, left in step_answers. Send and data
	// words update the model whatever commit is. A receive updates the pointers only when
	// commit is set. Returns 0 if the word would read a ring byte never written.
	function automatic bit ring_answers(logic [1:0] c, logic [LW-1:0] len,
		logic [7:0] b, bit commit);
		int  left, rp, fr, blen, n, a;
		bit  done, clean;
		clean = 1'b1;
		done = 1'b0;
		step_answers.delete();
		case (c)
			CMD_BEGIN: begin
				left = BUF_BYTES - wr_ptr;
				if (len > MAX_MSG) begin
					// too long: open send stays open
					note(STAT_NO_ROOM, 8'h00, 1'b1);
				end else begin
					owed = 0;
					if (len + HDR_BYTES >= left) begin
						if (rd_ptr != 0 && left < free_cnt) begin
							ring_put(wr_ptr, KIND_MARK);
							free_cnt -= left;
							wr_ptr = 0;
							note(STAT_WRAP, 8'h00, 1'b1);
						end else begin
							note(STAT_NO_ROOM, 8'h00, 1'b1);
						end
					end else if (free_cnt >= 1 && len + HDR_BYTES < free_cnt - 1) begin
						ring_put(wr_ptr, KIND_MSG);
						ring_put(wr_ptr + 1, {1'b0, len});
						for (int i = 2; i < HDR_BYTES; i++)
							ring_put(wr_ptr + i, 8'h00);
						free_cnt -= len + HDR_BYTES;
						wr_ptr = (wr_ptr + len + HDR_BYTES) % BUF_BYTES;
						owed = int'(len);
						note(STAT_OK, 8'h00, 1'b1);
					end else begin
						note(STAT_NO_ROOM, 8'h00, 1'b1);
					end
				end
			end
			CMD_DATA: begin
				if (owed == 0) begin
					note(STAT_NO_SEND, 8'h00, 1'b1);
				end else begin
					ring_put(wr_ptr + BUF_BYTES - owed, b);
					owed--;
					note(STAT_OK, 8'h00, 1'b1);
				end
			end
			CMD_RECV: begin
				rp = rd_ptr;
				fr = free_cnt;
				for (int pass = 0; pass < SKIP_LIMIT && !done; pass++) begin
					if (fr >= BUF_BYTES || wr_ptr == rp) begin
						note(STAT_EMPTY, 8'h00, 1'b1);
						done = 1'b1;
					end else begin
						clean &= ring_written[rp];
						if (ring_mem[rp] != KIND_MSG) begin
							// wrap marker: skip to the ring start
							fr += BUF_BYTES - rp;
							rp = 0;
						end else begin
							clean &= ring_written[(rp + 1) % BUF_BYTES];
							blen = int'(ring_mem[(rp + 1) % BUF_BYTES]);
							n = (blen > MAX_MSG) ? MAX_MSG : blen;
							if (n == 0)
								note(STAT_OK, 8'h00, 1'b1);
							for (int i = 0; i < n; i++) begin
								a = (rp + HDR_BYTES + i) % BUF_BYTES;
								clean &= ring_written[a];
								note(STAT_DATA, ring_mem[a], i + 1 == n);
							end
							rp = (rp + blen + HDR_BYTES) % BUF_BYTES;
							fr += blen + HDR_BYTES;
							if (fr > BUF_BYTES)
								fr = BUF_BYTES;
							done = 1'b1;
						end
					end
				end
				if (!done)
					note(STAT_EMPTY, 8'h00, 1'b1);
				if (commit) begin
					rd_ptr = rp;
					free_cnt = fr;
				end
			end
			default: note(STAT_NO_SEND, 8'h00, 1'b1);
		endcase
		return clean;
	endfunction

	// Drive one word, wait for it to be taken, queue its answers, then idle at random
	task automatic issue_word(logic [1:0] c, logic [LW-1:0] len, logic [7:0] b,
		bit known, status_t st);
		int gap;
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		msg_len <= len;
		data_byte <= b;
		// busy moves only at the rising edge, so its value here holds until then
		while (busy)
			@(negedge clk);
		@(posedge clk);
		void'(ring_answers(c, len, b, 1'b1));
		if (known)
			answers_due.push_back('{st, 8'h00, 1'b1});
		else
			foreach (step_answers[i])
				answers_due.push_back(step_answers[i]);
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// Mostly well-formed sends with random content, plus receives and noise
	task automatic random_word();
		logic [1:0]     c;
		logic [LW-1:0]  len;
		logic [7:0]     b;
		int             r, rl;
		c = CMD_BEGIN;
		b = 8'($urandom_range(0, 255));
		rl = $urandom_range(0, 99);
		if (rl < 45)
			len = LW'($urandom_range(0, 7));
		else if (rl < 75)
			len = LW'($urandom_range(8, 32));
		else if (rl < 92)
			len = LW'($urandom_range(33, MAX_MSG - 1));
		else
			len = LW'(MAX_MSG);
		r = $urandom_range(0, 99);
		if (owed != 0) begin
			if (r < 85)
				c = CMD_DATA;
			else if (r < 90)
				c = CMD_RECV;
			else if (r < 93)
				len = LW'($urandom_range(MAX_MSG + 1, 127));
			else if (r < 95)
				c = CMD_UNDEF;
			else begin
				// abandon the open send only over bytes filled on an earlier lap
				for (int i = 1; i <= owed; i++)
					if (!ring_written[(wr_ptr + BUF_BYTES - i) % BUF_BYTES])
						c = CMD_DATA;
			end
		end else begin
			if (r < recv_pct)
				c = CMD_RECV;
			else if (r >= 97)
				len = LW'($urandom_range(MAX_MSG + 1, 127));
			else if (r >= 95)
				c = CMD_UNDEF;
			else if (r >= 92)
				c = CMD_DATA;
		end
		// never let a receive read ring bytes that were not written
		if (c == CMD_RECV && !ring_answers(CMD_RECV, len, b, 1'b0))
			c = (owed != 0) ? CMD_DATA : CMD_BEGIN;
		issue_word(c, len, b, 1'b0, STAT_OK);
	endtask

	// Result checker
	always @(posedge clk) begin
		ring_answer_t want;
		if (arst_n && res_valid) begin
			if (answers_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, got %0d/%0d/%0d",
					$time, status, out_byte, last);
				errors++;
			end else begin
				want = answers_due.pop_front();
				if (status !== want.st) begin
					$display("%0t: status: expected %0d, got %0d", $time, want.st, status);
					errors++;
				end
				if (out_byte !== want.ob) begin
					$display("%0t: out_byte: expected %0d, got %0d", $time, want.ob, out_byte);
					errors++;
				end
				if (last !== want.lst) begin
					$display("%0t: last: expected %0d, got %0d", $time, want.lst, last);
					errors++;
				end
			end
		end
	end

	initial begin
		int n;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_BEGIN;
		msg_len = '0;
		data_byte = '0;
		errors = 0;
		cycle_count = 0;
		wr_ptr = 0;
		rd_ptr = 0;
		free_cnt = BUF_BYTES;
		owed = 0;
		idle_pct = 26;
		recv_pct = 30;
		for (int i = 0; i < BUF_BYTES; i++)
			ring_mem[i] = 8'h00;

		// Edge cases: empty ring, stray data, undefined command, lengths over
		// the limit (also while a send is open), zero-length message, byte extremes
		script = '{
			'{CMD_RECV,  7'd0,   8'h00, 1'b1, STAT_EMPTY},
			'{CMD_DATA,  7'd0,   8'hA5, 1'b1, STAT_NO_SEND},
			'{CMD_UNDEF, 7'd0,   8'h00, 1'b1, STAT_NO_SEND},
			'{CMD_BEGIN, 7'd100, 8'h00, 1'b1, STAT_NO_ROOM},
			'{CMD_BEGIN, 7'd127, 8'h00, 1'b1, STAT_NO_ROOM},
			'{CMD_BEGIN, 7'd0,   8'h00, 1'b1, STAT_OK},
			'{CMD_RECV,  7'd0,   8'h00, 1'b1, STAT_OK},
			'{CMD_RECV,  7'd0,   8'h00, 1'b1, STAT_EMPTY},
			'{CMD_BEGIN, 7'd3,   8'h00, 1'b1, STAT_OK},
			'{CMD_BEGIN, 7'd65,  8'h00, 1'b1, STAT_NO_ROOM},
			'{CMD_DATA,  7'd0,   8'h00, 1'b1, STAT_OK},
			'{CMD_DATA,  7'd0,   8'hFF, 1'b1, STAT_OK},
			'{CMD_DATA,  7'd0,   8'h5A, 1'b1, STAT_OK},
			'{CMD_DATA,  7'd0,   8'h33, 1'b1, STAT_NO_SEND},
			'{CMD_RECV,  7'd0,   8'h00, 1'b0, STAT_OK},
			'{CMD_BEGIN, 7'd1,   8'h00, 1'b1, STAT_OK},
			'{CMD_DATA,  7'd0,   8'h80, 1'b1, STAT_OK},
			'{CMD_BEGIN, 7'd2,   8'h00, 1'b1, STAT_OK},
			'{CMD_DATA,  7'd0,   8'h01, 1'b1, STAT_OK},
			'{CMD_DATA,  7'd0,   8'h7F, 1'b1, STAT_OK},
			'{CMD_RECV,  7'd0,   8'h00, 1'b0, STAT_OK},
			'{CMD_RECV,  7'd0,   8'h00, 1'b0, STAT_OK},
			'{CMD_RECV,  7'd0,   8'h00, 1'b1, STAT_EMPTY}
		};

		repeat (6)
			@(negedge clk);
		arst_n = 1'b1;

		foreach (script[i])
			issue_word(script[i].c, script[i].len, script[i].b, script[i].known,
				script[i].st);

		// Random words: sender idle 26%, then 83%, then never
		for (int p = 0; p < 3; p++) begin
			idle_pct = (p == 0) ? 26 : (p == 1) ? 83 : 0;
			n = 0;
			while (n < PHASE_WORDS) begin
				// receive rate changes in bursts so the ring both fills and drains
				if (n % 40 == 0)
					case ($urandom_range(0, 3))
						0: recv_pct = 0;
						1: recv_pct = 5;
						2: recv_pct = 30;
						default: recv_pct = 60;
					endcase
				random_word();
				n++;
			end
		end

		@(negedge clk);
		start <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT)
			@(posedge clk);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
